[rtl/ekf_pose_covariance_predict_core_assert.svh]
// assertion macros for the pose covariance predict core
// expects aclk and aresetn in the scope of the module that uses them
`ifndef EKF_POSE_COVARIANCE_PREDICT_CORE_ASSERT_SVH
`define EKF_POSE_COVARIANCE_PREDICT_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define EPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define EPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/epc_pkg.sv]
// shared types, constants and microprogram of the pose covariance predict core
// no dependencies
package epc_pkg;

    typedef struct packed {
        logic signed [15:0] steer_angle;
        logic signed [15:0] heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] cov_xx;
        logic signed [31:0] cov_xy;
        logic signed [31:0] cov_xt;
        logic signed [31:0] cov_yy;
        logic signed [31:0] cov_yt;
        logic signed [31:0] cov_tt;
    } out_t;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED     = 3'd0;
    localparam logic [2:0] REG_TIME_STEP = 3'd1;
    localparam logic [2:0] REG_WHEELBASE = 3'd2;
    localparam logic [2:0] REG_SPEED_VAR = 3'd3;
    localparam logic [2:0] REG_STEER_VAR = 3'd4;
    localparam logic [2:0] REG_COV_VS    = 3'd5;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [63:0] WIDE_LIM = 64'sd2305843009213693952;

    localparam int RF_DEPTH = 32;
    localparam int RF_AW = 5;
    localparam int LOAD_LAST = 14;

    // operation codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_MULN = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_POSE = 3'd4;

    // register file slots
    localparam logic [4:0] SL_PXX = 5'd0;
    localparam logic [4:0] SL_PXY = 5'd1;
    localparam logic [4:0] SL_PXT = 5'd2;
    localparam logic [4:0] SL_PYY = 5'd3;
    localparam logic [4:0] SL_PYT = 5'd4;
    localparam logic [4:0] SL_PTT = 5'd5;
    localparam logic [4:0] SL_VT  = 5'd6;
    localparam logic [4:0] SL_T   = 5'd7;
    localparam logic [4:0] SL_QV  = 5'd8;
    localparam logic [4:0] SL_QG  = 5'd9;
    localparam logic [4:0] SL_QC  = 5'd10;
    localparam logic [4:0] SL_S   = 5'd11;
    localparam logic [4:0] SL_C   = 5'd12;
    localparam logic [4:0] SL_SG  = 5'd13;
    localparam logic [4:0] SL_CG  = 5'd14;
    localparam logic [4:0] SL_A   = 5'd15;
    localparam logic [4:0] SL_B   = 5'd16;
    localparam logic [4:0] SL_U0  = 5'd17;
    localparam logic [4:0] SL_U1  = 5'd18;
    localparam logic [4:0] SL_U2  = 5'd19;
    localparam logic [4:0] SL_W2  = 5'd20;
    localparam logic [4:0] SL_TMP = 5'd21;
    localparam logic [4:0] SL_F2  = 5'd22;
    localparam logic [4:0] SL_F4  = 5'd23;
    localparam logic [4:0] SL_ACC = 5'd24;
    localparam logic [4:0] SL_F0  = 5'd25;
    localparam logic [4:0] SL_F1  = 5'd26;
    localparam logic [4:0] SL_F3  = 5'd27;
    // noise products reuse slots that are dead by then
    localparam logic [4:0] SL_T00 = 5'd0;
    localparam logic [4:0] SL_T01 = 5'd1;
    localparam logic [4:0] SL_T02 = 5'd2;
    localparam logic [4:0] SL_T10 = 5'd3;
    localparam logic [4:0] SL_T11 = 5'd4;
    localparam logic [4:0] SL_T12 = 5'd6;

    // pose destinations
    localparam logic [4:0] PD_XX = 5'd0;
    localparam logic [4:0] PD_XY = 5'd1;
    localparam logic [4:0] PD_XT = 5'd2;
    localparam logic [4:0] PD_YY = 5'd3;
    localparam logic [4:0] PD_YT = 5'd4;
    localparam logic [4:0] PD_TT = 5'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic [4:0] sh;
    } prog_t;

    localparam logic [5:0] PC_LAST = 6'd63;

    function automatic prog_t prog_at(input logic [5:0] pc);
        case (pc)
            6'd0:  return '{OP_MULN, SL_VT,  SL_S,   SL_A,   5'd24};
            6'd1:  return '{OP_MUL,  SL_VT,  SL_C,   SL_B,   5'd24};
            6'd2:  return '{OP_MUL,  SL_T,   SL_C,   SL_U0,  5'd16};
            6'd3:  return '{OP_MUL,  SL_T,   SL_S,   SL_U1,  5'd16};
            6'd4:  return '{OP_DIV,  SL_T,   SL_SG,  SL_U2,  5'd8};
            6'd5:  return '{OP_DIV,  SL_VT,  SL_CG,  SL_W2,  5'd16};
            // motion part
            6'd6:  return '{OP_MUL,  SL_A,   SL_PTT, SL_TMP, 5'd30};
            6'd7:  return '{OP_ADD,  SL_PXT, SL_TMP, SL_F2,  5'd0};
            6'd8:  return '{OP_MUL,  SL_B,   SL_PTT, SL_TMP, 5'd30};
            6'd9:  return '{OP_ADD,  SL_PYT, SL_TMP, SL_F4,  5'd0};
            6'd10: return '{OP_MUL,  SL_A,   SL_PXT, SL_TMP, 5'd30};
            6'd11: return '{OP_ADD,  SL_PXX, SL_TMP, SL_ACC, 5'd0};
            6'd12: return '{OP_MUL,  SL_A,   SL_F2,  SL_TMP, 5'd30};
            6'd13: return '{OP_ADD,  SL_ACC, SL_TMP, SL_F0,  5'd0};
            6'd14: return '{OP_MUL,  SL_A,   SL_PYT, SL_TMP, 5'd30};
            6'd15: return '{OP_ADD,  SL_PXY, SL_TMP, SL_ACC, 5'd0};
            6'd16: return '{OP_MUL,  SL_B,   SL_F2,  SL_TMP, 5'd30};
            6'd17: return '{OP_ADD,  SL_ACC, SL_TMP, SL_F1,  5'd0};
            6'd18: return '{OP_MUL,  SL_B,   SL_PYT, SL_TMP, 5'd30};
            6'd19: return '{OP_ADD,  SL_PYY, SL_TMP, SL_ACC, 5'd0};
            6'd20: return '{OP_MUL,  SL_B,   SL_F4,  SL_TMP, 5'd30};
            6'd21: return '{OP_ADD,  SL_ACC, SL_TMP, SL_F3,  5'd0};
            // noise times control jacobian, row 0
            6'd22: return '{OP_MUL,  SL_U0,  SL_QV,  SL_TMP, 5'd30};
            6'd23: return '{OP_MUL,  SL_A,   SL_QC,  SL_ACC, 5'd30};
            6'd24: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T00, 5'd0};
            6'd25: return '{OP_MUL,  SL_U0,  SL_QC,  SL_TMP, 5'd30};
            6'd26: return '{OP_MUL,  SL_A,   SL_QG,  SL_ACC, 5'd30};
            6'd27: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T10, 5'd0};
            // row 1
            6'd28: return '{OP_MUL,  SL_U1,  SL_QV,  SL_TMP, 5'd30};
            6'd29: return '{OP_MUL,  SL_B,   SL_QC,  SL_ACC, 5'd30};
            6'd30: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T01, 5'd0};
            6'd31: return '{OP_MUL,  SL_U1,  SL_QC,  SL_TMP, 5'd30};
            6'd32: return '{OP_MUL,  SL_B,   SL_QG,  SL_ACC, 5'd30};
            6'd33: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T11, 5'd0};
            // row 2
            6'd34: return '{OP_MUL,  SL_U2,  SL_QV,  SL_TMP, 5'd30};
            6'd35: return '{OP_MUL,  SL_W2,  SL_QC,  SL_ACC, 5'd30};
            6'd36: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T02, 5'd0};
            6'd37: return '{OP_MUL,  SL_U2,  SL_QC,  SL_TMP, 5'd30};
            6'd38: return '{OP_MUL,  SL_W2,  SL_QG,  SL_ACC, 5'd30};
            6'd39: return '{OP_ADD,  SL_TMP, SL_ACC, SL_T12, 5'd0};
            // xx
            6'd40: return '{OP_MUL,  SL_U0,  SL_T00, SL_TMP, 5'd30};
            6'd41: return '{OP_MUL,  SL_A,   SL_T10, SL_ACC, 5'd30};
            6'd42: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd43: return '{OP_POSE, SL_F0,  SL_ACC, PD_XX,  5'd0};
            // xy
            6'd44: return '{OP_MUL,  SL_U1,  SL_T00, SL_TMP, 5'd30};
            6'd45: return '{OP_MUL,  SL_B,   SL_T10, SL_ACC, 5'd30};
            6'd46: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd47: return '{OP_POSE, SL_F1,  SL_ACC, PD_XY,  5'd0};
            // xt
            6'd48: return '{OP_MUL,  SL_U2,  SL_T00, SL_TMP, 5'd30};
            6'd49: return '{OP_MUL,  SL_W2,  SL_T10, SL_ACC, 5'd30};
            6'd50: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd51: return '{OP_POSE, SL_F2,  SL_ACC, PD_XT,  5'd0};
            // yy
            6'd52: return '{OP_MUL,  SL_U1,  SL_T01, SL_TMP, 5'd30};
            6'd53: return '{OP_MUL,  SL_B,   SL_T11, SL_ACC, 5'd30};
            6'd54: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd55: return '{OP_POSE, SL_F3,  SL_ACC, PD_YY,  5'd0};
            // yt
            6'd56: return '{OP_MUL,  SL_U2,  SL_T01, SL_TMP, 5'd30};
            6'd57: return '{OP_MUL,  SL_W2,  SL_T11, SL_ACC, 5'd30};
            6'd58: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd59: return '{OP_POSE, SL_F4,  SL_ACC, PD_YT,  5'd0};
            // tt
            6'd60: return '{OP_MUL,  SL_U2,  SL_T02, SL_TMP, 5'd30};
            6'd61: return '{OP_MUL,  SL_W2,  SL_T12, SL_ACC, 5'd30};
            6'd62: return '{OP_ADD,  SL_TMP, SL_ACC, SL_ACC, 5'd0};
            6'd63: return '{OP_POSE, SL_PTT, SL_ACC, PD_TT,  5'd0};
            default: return '{OP_ADD, SL_TMP, SL_TMP, SL_TMP, 5'd0};
        endcase
    endfunction

    // arctangent table, 2^32 per full turn
    function automatic logic [29:0] atan_at(input logic [4:0] i);
        case (i)
            5'd0:  return 30'd536870912;
            5'd1:  return 30'd316933406;
            5'd2:  return 30'd167458907;
            5'd3:  return 30'd85004756;
            5'd4:  return 30'd42667331;
            5'd5:  return 30'd21354465;
            5'd6:  return 30'd10679838;
            5'd7:  return 30'd5340245;
            5'd8:  return 30'd2670163;
            5'd9:  return 30'd1335087;
            5'd10: return 30'd667544;
            5'd11: return 30'd333772;
            5'd12: return 30'd166886;
            5'd13: return 30'd83443;
            5'd14: return 30'd41722;
            5'd15: return 30'd20861;
            5'd16: return 30'd10430;
            5'd17: return 30'd5215;
            5'd18: return 30'd2608;
            5'd19: return 30'd1304;
            5'd20: return 30'd652;
            5'd21: return 30'd326;
            5'd22: return 30'd163;
            5'd23: return 30'd81;
            default: return 30'd0;
        endcase
    endfunction

    function automatic logic signed [63:0] clampl(input logic signed [63:0] v);
        if (v > WIDE_LIM) return WIDE_LIM;
        if (v < -WIDE_LIM) return -WIDE_LIM;
        return v;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = clampl(a) + clampl(b);
        return clampl(s);
    endfunction

    // magnitude after clamping, at most 2^61
    function automatic logic [61:0] mag62(input logic signed [63:0] v);
        logic signed [63:0] c;
        logic signed [63:0] n;
        c = clampl(v);
        n = -c;
        return c[63] ? n[61:0] : c[61:0];
    endfunction

endpackage

[rtl/epc_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module epc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ekf_pose_covariance_predict_core.sv]
// pose covariance predict core, top level
// depends on epc_pkg, epc_ram and ekf_pose_covariance_predict_core_assert.svh
//
// usage
// - input channel s_valid/s_ready/s_data carries one request: steering angle
//   and heading as binary angles; the result channel m_valid/m_ready/m_data
//   returns the six unique entries of the updated 3x3 pose covariance
// - cfg_we/cfg_index/cfg_data write speed, time step, wheelbase and the
//   control noise; write them only while no request is in flight
// - one request at a time: two 24-step cordic passes, a load of the register
//   file, then a 64-step microprogram on one shared multiply/add/divide unit:
//   36 multiplies, 26 adds and two divides
// - a new request is taken the cycle after the result is loaded
// - the divider (one quotient bit per cycle) and the 62x16 multiplier
//   (four passes per product) set the run time of a request
// - reset (aresetn low, synchronous) zeroes the covariance and loads the
//   default configuration
// - the result sits in an output register; if the receiver stalls, the next
//   request still runs and waits at its end until the register frees up
`include "ekf_pose_covariance_predict_core_assert.svh"

module ekf_pose_covariance_predict_core #(
    parameter int ANGLE_BITS = 16,
    parameter int COV_BITS   = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  epc_pkg::in_t     s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output epc_pkg::out_t    m_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CORD = 4'd1;
    localparam logic [3:0] ST_LOAD = 4'd2;
    localparam logic [3:0] ST_RDA  = 4'd3;
    localparam logic [3:0] ST_RDB  = 4'd4;
    localparam logic [3:0] ST_PREP = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_MFIN = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_WR   = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    localparam int ANG_SHIFT = 32 - ANGLE_BITS;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic signed [63:0] COV_HI = (64'sd1 <<< (COV_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] COV_LO = -COV_HI - 64'sd1;
    localparam logic [5:0] CORD_LAST = 6'(epc_pkg::CORDIC_STEPS - 1);

    // configuration
    logic [15:0] speed_reg, time_step_reg, wheelbase_reg;
    logic [30:0] speed_var_reg, steer_var_reg;
    logic [31:0] cov_vs_reg;

    // control
    logic [3:0] state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic       m_valid_reg, m_valid_next;

    // cordic
    logic [31:0]        g_reg, g_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [33:0] s_reg, s_next, c_reg, c_next, sg_reg, sg_next, cg_reg, cg_next;

    // arithmetic unit
    logic signed [63:0] opa_reg, opa_next, res_reg, res_next;
    logic [61:0]        ma_reg, ma_next;
    logic [63:0]        mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [127:0]       acc_reg, acc_next;
    logic [63:0]        num_reg, num_next;
    logic [32:0]        rem_reg, rem_next;

    logic signed [COV_BITS-1:0] pose_reg [6];
    logic signed [COV_BITS-1:0] pose_next [6];
    epc_pkg::out_t out_reg, out_next;

    // register file
    logic                       rf_we;
    logic [epc_pkg::RF_AW-1:0]  rf_waddr, rf_raddr;
    logic [63:0]                rf_wdata, rf_rdata;

    epc_ram #(
        .WIDTH(64),
        .DEPTH(epc_pkg::RF_DEPTH)
    ) u_rf (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    epc_pkg::prog_t prog;
    assign prog = epc_pkg::prog_at(pc_reg);

    // input angles widened to 32-bit binary angles
    logic [31:0] g_in, th_in, fold_ang, fold_a;
    logic        fold_flip;
    assign g_in  = ({16'b0, s_data.steer_angle} & ANG_MASK) << ANG_SHIFT;
    assign th_in = ({16'b0, s_data.heading} & ANG_MASK) << ANG_SHIFT;
    assign fold_ang  = (state_reg == ST_IDLE) ? (g_in + th_in) : g_reg;
    // fold into [-pi/2, pi/2): add pi and negate results later
    logic [31:0] fold_test;
    assign fold_test = fold_ang + 32'h4000_0000;
    assign fold_flip = fold_test[31];
    assign fold_a    = fold_flip ? (fold_ang ^ 32'h8000_0000) : fold_ang;

    // one cordic rotation
    logic signed [33:0] xs, ys, x_rot, y_rot, z_rot, cord_c, cord_s;
    logic [33:0]        atan_w;
    always_comb begin
        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
        atan_w = {4'b0, epc_pkg::atan_at(cnt_reg[4:0])};
        if (!z_reg[33]) begin
            x_rot = x_reg - ys;
            y_rot = y_reg + xs;
            z_rot = z_reg - $signed(atan_w);
        end else begin
            x_rot = x_reg + ys;
            y_rot = y_reg - xs;
            z_rot = z_reg + $signed(atan_w);
        end
        cord_c = flip_reg ? -x_rot : x_rot;
        cord_s = flip_reg ? -y_rot : y_rot;
    end

    // load values for the register file
    logic [31:0]        vt;
    logic signed [63:0] load_val;
    assign vt = 32'(speed_reg) * 32'(time_step_reg);
    always_comb begin
        case (cnt_reg[4:0])
            epc_pkg::SL_PXX, epc_pkg::SL_PXY, epc_pkg::SL_PXT,
            epc_pkg::SL_PYY, epc_pkg::SL_PYT, epc_pkg::SL_PTT:
                load_val = 64'(pose_reg[cnt_reg[2:0]]);
            epc_pkg::SL_VT: load_val = {32'b0, vt};
            epc_pkg::SL_T:  load_val = {48'b0, time_step_reg};
            epc_pkg::SL_QV: load_val = {33'b0, speed_var_reg};
            epc_pkg::SL_QG: load_val = {33'b0, steer_var_reg};
            epc_pkg::SL_QC: load_val = {{32{cov_vs_reg[31]}}, cov_vs_reg};
            epc_pkg::SL_S:  load_val = 64'(s_reg);
            epc_pkg::SL_C:  load_val = 64'(c_reg);
            epc_pkg::SL_SG: load_val = 64'(sg_reg);
            epc_pkg::SL_CG: load_val = 64'(cg_reg);
            default:        load_val = '0;
        endcase
    end

    // multiply: one 62x16 partial product a cycle, top chunk first
    logic [77:0]  pp;
    logic [127:0] mul_acc, rnd_sum, rnd_shr;
    logic [61:0]  mul_mag;
    logic signed [63:0] mul_res;
    assign pp      = ma_reg * mb_reg[63:48];
    assign mul_acc = (acc_reg << 16) + {50'b0, pp};
    assign rnd_sum = acc_reg + (128'd1 << (prog.sh - 5'd1));
    assign rnd_shr = rnd_sum >> prog.sh;
    assign mul_mag = (rnd_shr > {64'b0, epc_pkg::WIDE_LIM}) ? epc_pkg::WIDE_LIM[61:0]
                                                            : rnd_shr[61:0];
    assign mul_res = neg_reg ? -$signed({2'b0, mul_mag}) : $signed({2'b0, mul_mag});

    // divide: restoring, one quotient bit a cycle, divisor wheelbase << sh
    logic [15:0] wb_eff;
    logic [32:0] den, rem_sh, rem_sub;
    logic        q_bit;
    logic [63:0] num_sh;
    assign wb_eff  = (wheelbase_reg == 16'd0) ? 16'd1 : wheelbase_reg;
    assign den     = {17'b0, wb_eff} << prog.sh;
    assign rem_sh  = {rem_reg[31:0], num_reg[63]};
    assign q_bit   = rem_sh >= den;
    assign rem_sub = q_bit ? (rem_sh - den) : rem_sh;
    assign num_sh  = {num_reg[62:0], q_bit};

    // add path
    logic signed [63:0] add_sum, pose_sat;
    assign add_sum  = epc_pkg::sadd(opa_reg, $signed(rf_rdata));
    assign pose_sat = (add_sum > COV_HI) ? COV_HI : ((add_sum < COV_LO) ? COV_LO : add_sum);

    function automatic logic signed [31:0] sat32(input logic signed [COV_BITS-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (w < -64'sd2147483648) return 32'sh8000_0000;
        return w[31:0];
    endfunction

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        g_next       = g_reg;
        flip_next    = flip_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        sg_next      = sg_reg;
        cg_next      = cg_reg;
        opa_next     = opa_reg;
        res_next     = res_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        pose_next    = pose_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rf_we        = 1'b0;
        rf_waddr     = prog.dst;
        rf_wdata     = res_reg;
        rf_raddr     = prog.src_a;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    g_next    = g_in;
                    flip_next = fold_flip;
                    x_next    = epc_pkg::CORDIC_GAIN;
                    y_next    = '0;
                    z_next    = 34'($signed(fold_a));
                    sel_next  = 1'b0;
                    cnt_next  = '0;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                x_next   = x_rot;
                y_next   = y_rot;
                z_next   = z_rot;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CORD_LAST) begin
                    cnt_next = '0;
                    if (!sel_reg) begin
                        // heading plus steering done, start steering alone
                        s_next    = cord_s;
                        c_next    = cord_c;
                        sel_next  = 1'b1;
                        flip_next = fold_flip;
                        x_next    = epc_pkg::CORDIC_GAIN;
                        y_next    = '0;
                        z_next    = 34'($signed(fold_a));
                    end else begin
                        sg_next    = cord_s;
                        cg_next    = cord_c;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                rf_we    = 1'b1;
                rf_waddr = cnt_reg[4:0];
                rf_wdata = load_val;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(epc_pkg::LOAD_LAST)) begin
                    cnt_next   = '0;
                    pc_next    = '0;
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                rf_raddr   = prog.src_a;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                opa_next   = $signed(rf_rdata);
                rf_raddr   = prog.src_b;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (prog.op == epc_pkg::OP_ADD || prog.op == epc_pkg::OP_POSE) begin
                    res_next   = (prog.op == epc_pkg::OP_POSE) ? pose_sat : add_sum;
                    state_next = ST_WR;
                end else begin
                    ma_next  = epc_pkg::mag62(opa_reg);
                    mb_next  = {2'b0, epc_pkg::mag62($signed(rf_rdata))};
                    neg_next = opa_reg[63] ^ rf_rdata[63] ^ (prog.op == epc_pkg::OP_MULN);
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next = mul_acc;
                mb_next  = mb_reg << 16;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3) begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN: begin
                if (prog.op == epc_pkg::OP_DIV) begin
                    // exact product plus half the divisor
                    num_next   = acc_reg[63:0] + {32'b0, den[32:1]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    res_next   = mul_res;
                    state_next = ST_WR;
                end
            end
            ST_DIV: begin
                num_next = num_sh;
                rem_next = rem_sub;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    res_next   = neg_reg ? -$signed(num_sh) : $signed(num_sh);
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                if (prog.op == epc_pkg::OP_POSE) begin
                    pose_next[prog.dst[2:0]] = res_reg[COV_BITS-1:0];
                end else begin
                    rf_we = 1'b1;
                end
                if (pc_reg == epc_pkg::PC_LAST) begin
                    state_next = ST_FIN;
                end else begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = ST_RDA;
                end
            end
            ST_FIN: begin
                // hold here while the previous result is still unread
                if (!m_valid_reg || m_ready) begin
                    out_next.cov_xx = sat32(pose_reg[0]);
                    out_next.cov_xy = sat32(pose_reg[1]);
                    out_next.cov_xt = sat32(pose_reg[2]);
                    out_next.cov_yy = sat32(pose_reg[3]);
                    out_next.cov_yt = sat32(pose_reg[4]);
                    out_next.cov_tt = sat32(pose_reg[5]);
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            speed_reg     <= 16'd256;
            time_step_reg <= 16'd1638;
            wheelbase_reg <= 16'd256;
            speed_var_reg <= '0;
            steer_var_reg <= '0;
            cov_vs_reg    <= '0;
            for (int i = 0; i < 6; i++) begin
                pose_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
            pose_reg    <= pose_next;
            if (cfg_we) begin
                case (cfg_index)
                    epc_pkg::REG_SPEED:     speed_reg     <= cfg_data[15:0];
                    epc_pkg::REG_TIME_STEP: time_step_reg <= cfg_data[15:0];
                    epc_pkg::REG_WHEELBASE: wheelbase_reg <= cfg_data[15:0];
                    epc_pkg::REG_SPEED_VAR: speed_var_reg <= cfg_data[30:0];
                    epc_pkg::REG_STEER_VAR: steer_var_reg <= cfg_data[30:0];
                    epc_pkg::REG_COV_VS:    cov_vs_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        g_reg    <= g_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        s_reg    <= s_next;
        c_reg    <= c_next;
        sg_reg   <= sg_next;
        cg_reg   <= cg_next;
        opa_reg  <= opa_next;
        res_reg  <= res_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `EPC_ASSERT_NEXT(a_one_request, s_valid && s_ready, !s_ready, "request taken while busy")
    `EPC_ASSERT_SAME(a_cordic_count, state_reg == ST_CORD, cnt_reg <= CORD_LAST, "cordic overrun")
    `EPC_ASSERT_NEXT(a_prog_end, state_reg == ST_WR && pc_reg == epc_pkg::PC_LAST, state_reg == ST_FIN, "program end missed")
    `EPC_ASSERT_SAME(a_result_source, $rose(m_valid_reg), $past(state_reg) == ST_FIN, "result without finish")

endmodule

[tb/ekf_pose_covariance_predict_core_tb.sv]
// testbench for the pose covariance predict core: directed and random requests
// checked against a bit-exact predictor of the fixed-point covariance update
// depends on epc_pkg and ekf_pose_covariance_predict_core
module ekf_pose_covariance_predict_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_NONE_LO = 3'd6;   // indexes past the register list
    localparam logic [2:0] REG_NONE_HI = 3'd7;
    localparam longint LIM = 64'sd2305843009213693952;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 700;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    epc_pkg::in_t s_data;
    epc_pkg::out_t m_data;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    ekf_pose_covariance_predict_core i_dut (.*);

    // predictor state: configuration and the stored covariance
    longint unsigned cur_speed, cur_tstep, cur_wbase, cur_qv, cur_qg, cur_qc;
    longint pose[6];
    epc_pkg::out_t cov_q[$];
    int n_req, n_res, n_err, idle_cycles, burst_left;
    longint unsigned cyc;
    int stall_left;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clip_wide(longint v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clip_wide(clip_wide(a) + clip_wide(b));
    endfunction

    function automatic longint clip_bits(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // product shifted down, magnitude rounded half away from zero, saturated
    function automatic longint mul_round(longint a, longint b, int sh);
        logic neg;
        logic [127:0] p;
        longint unsigned ua, ub;
        neg = (a < 0) != (b < 0);
        a = clip_wide(a);
        b = clip_wide(b);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(LIM)) p = 128'(LIM);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned m;
        longint q;
        m = num < 0 ? -num : num;
        q = longint'((m + den / 2) / den);
        return num < 0 ? -q : q;
    endfunction

    // 24-step rotation on the angle folded into [-pi/2, pi/2)
    task automatic rotate(input logic [31:0] ang, output longint sn, output longint cs);
        logic flip;
        longint x, y, z, nx;
        logic [29:0] atan_step [24];
        atan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
        flip = ang[31] ^ ang[30];
        if (flip) ang = ang - 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(ang));
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    task automatic predict_cov(input epc_pkg::in_t d, output epc_pkg::out_t r);
        logic [31:0] g, th;
        longint s, c, sg, cg, vt, a, b, qv, qg, qc;
        longint u[3], w[3], t0[3], t1[3], f[6], nz[6];
        longint unsigned wb;
        int ri[6], rj[6];
        ri = '{0, 0, 0, 1, 1, 2};
        rj = '{0, 1, 2, 1, 2, 2};
        g = {d.steer_angle, 16'd0};
        th = {d.heading, 16'd0};
        rotate(g + th, s, c);
        rotate(g, sg, cg);
        qv = cur_qv; qg = cur_qg;
        qc = longint'(signed'(cur_qc[31:0]));
        wb = cur_wbase != 0 ? cur_wbase : 1;
        vt = cur_speed * cur_tstep;
        a = -mul_round(vt, s, 24);
        b = mul_round(vt, c, 24);
        u[0] = mul_round(cur_tstep, c, 16); w[0] = a;
        u[1] = mul_round(cur_tstep, s, 16); w[1] = b;
        u[2] = div_round(longint'(cur_tstep) * sg, wb << 8);
        w[2] = div_round(vt * cg, wb << 16);
        f[2] = add_sat(pose[2], mul_round(a, pose[5], 30));
        f[4] = add_sat(pose[4], mul_round(b, pose[5], 30));
        f[0] = add_sat(add_sat(pose[0], mul_round(a, pose[2], 30)), mul_round(a, f[2], 30));
        f[1] = add_sat(add_sat(pose[1], mul_round(a, pose[4], 30)), mul_round(b, f[2], 30));
        f[3] = add_sat(add_sat(pose[3], mul_round(b, pose[4], 30)), mul_round(b, f[4], 30));
        f[5] = pose[5];
        for (int i = 0; i < 3; i++) begin
            t0[i] = add_sat(mul_round(u[i], qv, 30), mul_round(w[i], qc, 30));
            t1[i] = add_sat(mul_round(u[i], qc, 30), mul_round(w[i], qg, 30));
        end
        for (int k = 0; k < 6; k++) begin
            nz[k] = add_sat(mul_round(u[rj[k]], t0[ri[k]], 30),
                            mul_round(w[rj[k]], t1[ri[k]], 30));
            pose[k] = clip_bits(add_sat(f[k], nz[k]), 32);
        end
        r.cov_xx = pose[0][31:0]; r.cov_xy = pose[1][31:0]; r.cov_xt = pose[2][31:0];
        r.cov_yy = pose[3][31:0]; r.cov_yt = pose[4][31:0]; r.cov_tt = pose[5][31:0];
    endtask

    // one request, sent in bursts with random gaps in between
    task automatic send_req(input epc_pkg::in_t d);
        epc_pkg::out_t r;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        predict_cov(d, r);
        cov_q.push_back(r);
        n_req++;
    endtask

    // pause the sender until every result is back
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (cov_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            epc_pkg::REG_SPEED:     cur_speed = val[15:0];
            epc_pkg::REG_TIME_STEP: cur_tstep = val[15:0];
            epc_pkg::REG_WHEELBASE: cur_wbase = val[15:0];
            epc_pkg::REG_SPEED_VAR: cur_qv = val[30:0];
            epc_pkg::REG_STEER_VAR: cur_qg = val[30:0];
            epc_pkg::REG_COV_VS:    cur_qc = val;
            default: ;
        endcase
    endtask

    task automatic send_angles(input logic [15:0] sa, input logic [15:0] hd);
        epc_pkg::in_t d;
        d.steer_angle = sa;
        d.heading = hd;
        send_req(d);
    endtask

    // reset defaults: zero noise keeps the covariance at zero
    task automatic test_defaults;
        send_angles(16'h0000, 16'h0000);
        send_angles(16'h7fff, 16'h8000);
        send_angles(16'h8000, 16'h7fff);
        send_angles(16'h4000, 16'hc000);
        drain;
    endtask

    // extremes of every register and of the angles, saturation included
    task automatic test_extremes;
        write_reg(epc_pkg::REG_SPEED_VAR, 32'h0001_0000);
        write_reg(epc_pkg::REG_STEER_VAR, 32'h0000_4000);
        write_reg(epc_pkg::REG_COV_VS, 32'hffff_f000);
        send_angles(16'h0000, 16'h0000);
        send_angles(16'h4000, 16'h4000);
        send_angles(16'hc000, 16'h8000);
        send_angles(16'hffff, 16'h0001);
        send_angles(16'h2000, 16'hffff);
        drain;
        // index past the list must change nothing
        write_reg(REG_NONE_LO, 32'hffff_ffff);
        write_reg(REG_NONE_HI, 32'h1234_5678);
        send_angles(16'h1000, 16'h0800);
        drain;
        // zero wheelbase acts as the smallest one
        write_reg(epc_pkg::REG_WHEELBASE, 32'h0000_0000);
        send_angles(16'h0400, 16'h0200);
        send_angles(16'hfc00, 16'h7000);
        drain;
        // speed, time step and variances at their top, wheelbase 1, cross term most negative
        write_reg(epc_pkg::REG_SPEED, 32'hffff_ffff);
        write_reg(epc_pkg::REG_TIME_STEP, 32'hffff_ffff);
        write_reg(epc_pkg::REG_WHEELBASE, 32'h0000_0001);
        write_reg(epc_pkg::REG_SPEED_VAR, 32'hffff_ffff);
        write_reg(epc_pkg::REG_STEER_VAR, 32'h7fff_ffff);
        write_reg(epc_pkg::REG_COV_VS, 32'h8000_0000);
        send_angles(16'h3000, 16'h1000);
        send_angles(16'h8000, 16'h8000);
        send_angles(16'h7fff, 16'h7fff);
        drain;
        write_reg(epc_pkg::REG_COV_VS, 32'h7fff_ffff);
        send_angles(16'h5555, 16'haaaa);
        drain;
        write_reg(epc_pkg::REG_SPEED, 32'h0000_0000);
        write_reg(epc_pkg::REG_TIME_STEP, 32'h0000_0000);
        write_reg(epc_pkg::REG_WHEELBASE, 32'h0000_ffff);
        send_angles(16'h0100, 16'h0100);
        drain;
    endtask

    function automatic logic [31:0] pick_val(input logic [31:0] top, input logic [31:0] typ);
        case ($urandom_range(0, 5))
            0: return top;
            1: return 32'd0;
            2: return $urandom;
            default: return $urandom_range(0, typ);
        endcase
    endfunction

    // random configurations, each followed by random steering and heading
    task automatic test_random;
        epc_pkg::in_t d;
        for (int ph = 0; ph < 9; ph++) begin
            drain;
            write_reg(epc_pkg::REG_SPEED, pick_val(32'hffff, 32'h0800));
            write_reg(epc_pkg::REG_TIME_STEP, pick_val(32'hffff, 32'h2000));
            write_reg(epc_pkg::REG_WHEELBASE, pick_val(32'hffff, 32'h0400));
            write_reg(epc_pkg::REG_SPEED_VAR, pick_val(32'h7fff_ffff, 32'h0004_0000));
            write_reg(epc_pkg::REG_STEER_VAR, pick_val(32'h7fff_ffff, 32'h0004_0000));
            write_reg(epc_pkg::REG_COV_VS, $urandom_range(0, 1) ? $urandom
                                  : 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000));
            for (int i = 0; i < 96; i++) begin
                d = $urandom;
                send_req(d);
            end
        end
        drain;
    endtask

    // result checker, receiver stalls and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            cyc++;
            if (m_valid && m_ready) begin
                n_res++;
                if (cov_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %h", m_data);
                end else begin
                    if (m_data.cov_xx !== cov_q[0].cov_xx || m_data.cov_xy !== cov_q[0].cov_xy ||
                        m_data.cov_xt !== cov_q[0].cov_xt || m_data.cov_yy !== cov_q[0].cov_yy ||
                        m_data.cov_yt !== cov_q[0].cov_yt || m_data.cov_tt !== cov_q[0].cov_tt)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("result %0d: expected %h got %h", n_res, cov_q[0], m_data);
                    end
                    void'(cov_q.pop_front());
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            // stretches of full readiness alternate with random stalls
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ((cyc / 4000) % 3 != 0 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 60);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = epc_pkg::REG_SPEED;
        cfg_data = '0;
        cur_speed = 256; cur_tstep = 1638; cur_wbase = 256;
        cur_qv = 0; cur_qg = 0; cur_qc = 0;
        foreach (pose[k]) pose[k] = 0;
        n_req = 0; n_res = 0; n_err = 0; idle_cycles = 0; burst_left = 0;
        cyc = 0; stall_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults;
        test_extremes;
        test_random;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (cov_q.size() != 0) n_err++;
        $display("covered %0d requests over reset defaults, register extremes, zero wheelbase,",
                 n_req);
        $display("ignored indexes and 9 random configurations; %0d results, %0d mismatches",
                 n_res, n_err);
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
